// ===== rtl/rsort_pkg.sv =====
// Shared constants and types for the scan result signal strength sorter.
`default_nettype none

package rsort_pkg;

    // Store capacity in records.
    localparam int MAX_ENTRIES = 16;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

    // One stored network record.
    typedef struct packed {
        logic signed [7:0] rssi;
        logic [3:0]        channel;
        logic [7:0]        security;
        logic              hidden;
        logic [7:0]        handle;
    } rec_t;

    // Access request from the sequencer to the record store.
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [ADDR_W-1:0] rd_addr;
    } mem_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/rsort_store.sv =====
// Record store: one write port and one registered read port.
`default_nettype none

module rsort_store (
    input  wire logic              clk,
    input  wire rsort_pkg::mem_ctl_t ctl,
    input  wire rsort_pkg::rec_t   wr_data,
    output rsort_pkg::rec_t        rd_data
);

    rsort_pkg::rec_t mem [rsort_pkg::MAX_ENTRIES];
    rsort_pkg::rec_t rd_data_reg;

    // The contents are undefined until written; the sequencer only uses data read
    // from entries it has written in the current batch.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[ctl.rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/scan_result_rssi_sorter.sv =====
// Top level of the scan result sorter: sequencer, compare unit and output register.
`default_nettype none

// The sorter collects the network records of one scan batch and keeps them in
// descending order of signal strength, records of equal strength staying in
// arrival order. Records arriving once the store holds MAX_ENTRIES records are
// dropped, and a record with an empty name is marked hidden. When the item
// flagged batch_end arrives (with or without a record of its own), all stored
// records are sent strongest first, the last one flagged final_entry, and the
// store is emptied; an empty batch sends nothing. Insertion walks down the
// store with one signed comparator and one memory port: for each stored record
// that it passes, it reads the entry above the hole and shifts it down a slot,
// then writes the new record into the hole. Each sorted result is read through
// the single read port, loaded into the output register and held there until
// the receiver takes it. The block stalls its input for the whole time an item
// is being inserted or its batch is being sent.
module scan_result_rssi_sorter (
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              has_entry,
    input  wire logic signed [7:0] signal_dbm,
    input  wire logic [3:0]        radio_channel,
    input  wire logic [7:0]        security_kind,
    input  wire logic [5:0]        name_length,
    input  wire logic [7:0]        record_handle,
    input  wire logic              batch_end,

    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic signed [7:0]      out_signal_dbm,
    output logic [3:0]             out_channel,
    output logic [7:0]             out_security,
    output logic                   is_hidden,
    output logic [7:0]             out_handle,
    output logic                   final_entry
);

    localparam int ADDR_W = rsort_pkg::ADDR_W;
    localparam int CNT_W  = rsort_pkg::CNT_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,  // waiting for an item
        S_SCAN  = 6'b000010,  // read the entry above the hole, or fill slot zero
        S_CMP   = 6'b000100,  // compare and shift down, or drop the record in
        S_ERD   = 6'b001000,  // read the next entry to send
        S_ELD   = 6'b010000,  // load the output register
        S_EWAIT = 6'b100000   // hold the result until it is taken
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [ADDR_W-1:0]    pos_reg, pos_next;
    logic [ADDR_W-1:0]    idx_reg, idx_next;
    logic                 end_reg, end_next;
    rsort_pkg::rec_t      new_reg;
    rsort_pkg::rec_t      out_reg;
    logic                 final_reg;
    logic                 out_valid_reg, out_valid_next;

    rsort_pkg::mem_ctl_t  mem_ctl;
    rsort_pkg::rec_t      wr_data;
    rsort_pkg::rec_t      rd_data;

    logic                 in_acc;
    logic                 out_acc;
    logic                 weaker;
    logic                 last_idx;

    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = out_valid_reg && !out_stall;
    assign in_stall = (state_reg != S_IDLE);

    // The one compare unit: is the stored entry strictly weaker than the new one?
    assign weaker   = ($signed(rd_data.rssi) < $signed(new_reg.rssi));
    assign last_idx = (CNT_W'(idx_reg) == (count_reg - CNT_W'(1)));

    rsort_store u_store (
        .clk     (clk),
        .ctl     (mem_ctl),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        end_next       = end_reg;
        out_valid_next = out_valid_reg;
        mem_ctl.wr_en  = 1'b0;
        mem_ctl.wr_addr = pos_reg;
        mem_ctl.rd_addr = idx_reg;
        wr_data        = new_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    end_next = batch_end;
                    idx_next = '0;
                    if (has_entry && (count_reg < rsort_pkg::MAX_CNT))
                    begin
                        pos_next   = count_reg[ADDR_W-1:0];
                        state_next = S_SCAN;
                    end
                    else if (batch_end && (count_reg != '0))
                    begin
                        state_next = S_ERD;
                    end
                end
            end
            S_SCAN:
            begin
                if (pos_reg == '0)
                begin
                    mem_ctl.wr_en = 1'b1;
                    count_next    = count_reg + CNT_W'(1);
                    state_next    = end_reg ? S_ERD : S_IDLE;
                end
                else
                begin
                    mem_ctl.rd_addr = pos_reg - ADDR_W'(1);
                    state_next      = S_CMP;
                end
            end
            S_CMP:
            begin
                mem_ctl.wr_en = 1'b1;
                if (weaker)
                begin
                    // Move the weaker entry down one slot and keep walking up.
                    wr_data    = rd_data;
                    pos_next   = pos_reg - ADDR_W'(1);
                    state_next = S_SCAN;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    state_next = end_reg ? S_ERD : S_IDLE;
                end
            end
            S_ERD:
            begin
                state_next = S_ELD;
            end
            S_ELD:
            begin
                out_valid_next = 1'b1;
                state_next     = S_EWAIT;
            end
            S_EWAIT:
            begin
                if (out_acc)
                begin
                    out_valid_next = 1'b0;
                    if (final_reg)
                    begin
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + ADDR_W'(1);
                        state_next = S_ERD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pos_reg       <= '0;
            idx_reg       <= '0;
            end_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            idx_reg       <= idx_next;
            end_reg       <= end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            new_reg.rssi     <= signal_dbm;
            new_reg.channel  <= radio_channel;
            new_reg.security <= security_kind;
            new_reg.hidden   <= (name_length == 6'd0);
            new_reg.handle   <= record_handle;
        end
        if (state_reg == S_ELD)
        begin
            out_reg   <= rd_data;
            final_reg <= last_idx;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_signal_dbm = out_reg.rssi;
    assign out_channel    = out_reg.channel;
    assign out_security   = out_reg.security;
    assign is_hidden      = out_reg.hidden;
    assign out_handle     = out_reg.handle;
    assign final_entry    = final_reg;

    // The store never reports more records than it can hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= rsort_pkg::MAX_CNT)
        else $error("record count exceeds capacity");

    // A result is never pending while a new item can be taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !out_valid)
        else $error("input ready while a result is pending");

    // Taking the final result empties the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && final_entry && !out_stall) |=> (count_reg == '0))
        else $error("store not emptied after final result");

    // The insertion hole never lies beyond the filled part of the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (CNT_W'(pos_reg) <= count_reg))
        else $error("insertion position beyond stored count");

    // Sending only starts when the store holds at least one record.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ERD) |-> (count_reg != '0))
        else $error("emitting from an empty store");

endmodule

`default_nettype wire
